>>> design/tfd_pkg.sv
`default_nettype none
package tfd_pkg;

    // View format codes that the decoder understands.
    localparam logic [6:0] FMT_RGBA32F   = 7'd2;
    localparam logic [6:0] FMT_RGBA16F   = 7'd10;
    localparam logic [6:0] FMT_RG32F     = 7'd16;
    localparam logic [6:0] FMT_D32S8     = 7'd21;
    localparam logic [6:0] FMT_R11G11B10 = 7'd26;
    localparam logic [6:0] FMT_RG16F     = 7'd34;
    localparam logic [6:0] FMT_R32F      = 7'd41;
    localparam logic [6:0] FMT_R24UNORM  = 7'd46;
    localparam logic [6:0] FMT_R16F      = 7'd54;
    localparam logic [6:0] FMT_R16UNORM  = 7'd56;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    typedef logic [31:0] t_word;

    // Widen a float with a 5-bit exponent and a 10-bit mantissa to float32.
    // Smaller mantissas are left-aligned into the 10 bits by the caller.
    function automatic t_word half_to_f32(input logic s, input logic [4:0] e,
                                          input logic [9:0] m);
        logic [3:0]  p;
        logic [10:0] sh;
        t_word       res;
        p   = 4'd0;
        sh  = 11'd0;
        res = {s, 31'd0};
        if (e == 5'd0) begin
            if (m != 10'd0) begin
                for (int i = 0; i < 10; i++) begin
                    if (m[i]) begin
                        p = 4'(i);
                    end
                end
                sh  = {1'b0, m} << (4'd10 - p);
                res = {s, 8'(p) + 8'd103, sh[9:0], 13'd0};
            end
        end else if (e == 5'd31) begin
            res = (m == 10'd0) ? (INF_BITS | {s, 31'd0}) : (QNAN_BITS | {s, 31'd0});
        end else begin
            res = {s, 8'(e) + 8'd112, m, 13'd0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> design/texel_format_to_float_decoder.sv
`default_nettype none
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_texel_low, i_texel_high
// output    out        o_out_valid / i_out_stall    o_value_red/green/blue, o_value_count
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_format_code
//
// Four register stages: input capture, format decode and half widening,
// unorm normalize shift, unorm rounding into the output register. One item
// enters every cycle unless the output is stalled. Reset (synchronous, active
// low) clears the valid bits and the format register. When the output item is
// stalled the whole pipeline holds, so nothing is lost or repeated.
module texel_format_to_float_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_texel_low,
    input  wire logic [31:0] i_texel_high,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_value_red,
    output logic      [31:0] o_value_green,
    output logic      [31:0] o_value_blue,
    output logic      [1:0]  o_value_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_format_code
);

    logic en;

    logic [6:0]  r_fmt;

    logic        r1_valid;
    logic [6:0]  r1_fmt;
    logic [63:0] r1_lo;
    logic [31:0] r1_hi;

    logic        r2_valid;
    logic        r2_unorm;
    logic [1:0]  r2_count;
    logic [31:0] r2_v0, r2_v1, r2_v2;
    logic        n2_unorm;
    logic [1:0]  n2_count;
    logic [31:0] n2_v0, n2_v1, n2_v2;

    logic        r3_valid;
    logic        r3_unorm;
    logic [1:0]  r3_count;
    logic [31:0] r3_v0, r3_v1, r3_v2;

    logic        r_out_valid;
    logic [31:0] r_out_v0, r_out_v1, r_out_v2;
    logic [1:0]  r_out_count;

    logic [31:0] w0;
    logic [31:0] unorm_bits;

    // The pipeline moves whenever the output register is free or drained.
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 7'd0;
        end else if (i_cfg_valid) begin
            r_fmt <= i_cfg_format_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_in_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_fmt <= r_fmt;
            r1_lo  <= i_texel_low;
            r1_hi  <= i_texel_high;
        end
    end

    assign w0 = r1_lo[31:0];

    // Decode the format and produce every value that needs no division.
    always_comb begin
        n2_v0    = 32'd0;
        n2_v1    = 32'd0;
        n2_v2    = 32'd0;
        n2_count = 2'd0;
        n2_unorm = 1'b0;
        unique case (r1_fmt)
            tfd_pkg::FMT_RGBA32F: begin
                n2_v0    = w0;
                n2_v1    = r1_lo[63:32];
                n2_v2    = r1_hi;
                n2_count = 2'd3;
            end
            tfd_pkg::FMT_RG32F: begin
                n2_v0    = w0;
                n2_v1    = r1_lo[63:32];
                n2_count = 2'd2;
            end
            tfd_pkg::FMT_D32S8, tfd_pkg::FMT_R32F: begin
                n2_v0    = w0;
                n2_count = 2'd1;
            end
            tfd_pkg::FMT_RGBA16F: begin
                n2_v0 = tfd_pkg::half_to_f32(r1_lo[15], r1_lo[14:10], r1_lo[9:0]);
                n2_v1 = tfd_pkg::half_to_f32(r1_lo[31], r1_lo[30:26], r1_lo[25:16]);
                n2_v2 = tfd_pkg::half_to_f32(r1_lo[47], r1_lo[46:42], r1_lo[41:32]);
                n2_count = 2'd3;
            end
            tfd_pkg::FMT_RG16F: begin
                n2_v0 = tfd_pkg::half_to_f32(r1_lo[15], r1_lo[14:10], r1_lo[9:0]);
                n2_v1 = tfd_pkg::half_to_f32(r1_lo[31], r1_lo[30:26], r1_lo[25:16]);
                n2_count = 2'd2;
            end
            tfd_pkg::FMT_R16F: begin
                n2_v0 = tfd_pkg::half_to_f32(r1_lo[15], r1_lo[14:10], r1_lo[9:0]);
                n2_count = 2'd1;
            end
            tfd_pkg::FMT_R11G11B10: begin
                // Small floats carry no sign; the mantissa is left-aligned.
                n2_v0 = tfd_pkg::half_to_f32(1'b0, w0[10:6], {w0[5:0], 4'd0});
                n2_v1 = tfd_pkg::half_to_f32(1'b0, w0[21:17], {w0[16:11], 4'd0});
                n2_v2 = tfd_pkg::half_to_f32(1'b0, w0[31:27], {w0[26:22], 5'd0});
                n2_count = 2'd3;
            end
            tfd_pkg::FMT_R24UNORM, tfd_pkg::FMT_R16UNORM: begin
                n2_unorm = 1'b1;
                n2_count = 2'd1;
            end
            default: begin
                n2_count = 2'd0;
            end
        endcase
    end

    tfd_unorm u_unorm (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value ((r1_fmt == tfd_pkg::FMT_R24UNORM) ? w0[23:0] : {8'd0, w0[15:0]}),
        .i_wide  (r1_fmt == tfd_pkg::FMT_R24UNORM),
        .o_bits  (unorm_bits)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_v0    <= n2_v0;
            r2_v1    <= n2_v1;
            r2_v2    <= n2_v2;
            r2_count <= n2_count;
            r2_unorm <= n2_unorm;
            r3_v0    <= r2_v0;
            r3_v1    <= r2_v1;
            r3_v2    <= r2_v2;
            r3_count <= r2_count;
            r3_unorm <= r2_unorm;
            r_out_v0    <= r3_unorm ? unorm_bits : r3_v0;
            r_out_v1    <= r3_v1;
            r_out_v2    <= r3_v2;
            r_out_count <= r3_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_red   = r_out_v0;
    assign o_value_green = r_out_v1;
    assign o_value_blue  = r_out_v2;
    assign o_value_count = r_out_count;

endmodule
`default_nettype wire

>>> design/tfd_unorm.sv
`default_nettype none
// Two-stage unorm to float32 converter: v / (2^n - 1) for n = 24 or 16.
// The quotient's binary expansion is v repeated, so the mantissa is a
// rotation of v and the tail after the round bit is never zero.
module tfd_unorm (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [23:0] i_value,
    input  wire logic        i_wide,
    output logic      [31:0] o_bits
);

    logic [23:0] r_a_value;
    logic [4:0]  r_a_p;
    logic        r_a_wide;
    logic        r_a_zero;
    logic [4:0]  n_a_p;

    logic [24:0] r_b_man;
    logic [7:0]  r_b_exp;
    logic        r_b_zero;

    logic [47:0] pattern;
    logic [47:0] shifted;
    logic [4:0]  shamt;
    logic [24:0] rounded;

    always_comb begin
        n_a_p = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (i_value[i]) begin
                n_a_p = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_value <= i_value;
            r_a_p     <= n_a_p;
            r_a_wide  <= i_wide;
            r_a_zero  <= (i_value == 24'd0);
        end
    end

    always_comb begin
        pattern = r_a_wide ? {r_a_value, r_a_value}
                           : {r_a_value[15:0], r_a_value[15:0], r_a_value[15:0]};
        shamt   = r_a_wide ? (5'd23 - r_a_p) : (5'd15 - r_a_p);
        shifted = pattern << shamt;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_man  <= shifted[47:23];
            r_b_exp  <= r_a_wide ? (8'd103 + 8'(r_a_p)) : (8'd111 + 8'(r_a_p));
            r_b_zero <= r_a_zero;
        end
    end

    // Round up when the round bit is set; a tie cannot occur.
    always_comb begin
        rounded = {1'b0, r_b_man[24:1]} + 25'(r_b_man[0]);
        if (r_b_zero) begin
            o_bits = 32'd0;
        end else if (rounded[24]) begin
            o_bits = {1'b0, r_b_exp + 8'd1, 23'd0};
        end else begin
            o_bits = {1'b0, r_b_exp, rounded[22:0]};
        end
    end

endmodule
`default_nettype wire
